>>> design/sha_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha_pkg
// Shared types, round constants and mixing functions for the SHA-256/224 core.
// -----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CntW   = 61;
  localparam int unsigned NumCv  = 8;
  localparam int unsigned NumBuf = 16;
  localparam int unsigned NumRnd = 64;

  localparam logic [5:0] PosLast = 6'h3F;
  localparam logic [5:0] PosLen  = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [2:0] MaxBytes = 3'd4;
  localparam logic [2:0] LastIdx256 = 3'd7;
  localparam logic [2:0] LastIdx224 = 3'd6;

  typedef enum logic [3:0] {
    StIdle,
    StByte,
    StPad80,
    StPadZero,
    StLen,
    StRound,
    StAdd,
    StEmit
  } state_e;

  typedef enum logic [1:0] {
    SrcData,
    SrcPad,
    SrcZero
  } byte_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      cfg_we;
    logic      load_in;
    logic      wr_byte;
    byte_src_e byte_src;
    logic [1:0] byte_idx;
    logic      cap_len;
    logic      wr_len;
    logic      start_cmp;
    logic      round;
    logic [5:0] rnd;
    logic      add_chain;
    logic      reload_iv;
    logic [2:0] out_idx;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pos_end;
    logic pos_len;
    logic variant;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] a);
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] e);
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] y);
    small_s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
  endfunction

  function automatic logic [31:0] init_value(input logic variant, input logic [2:0] i);
    logic [31:0] r;
    r = 32'h0;
    if (variant) begin
      unique case (i)
        3'd0: r = 32'hC1059ED8;
        3'd1: r = 32'h367CD507;
        3'd2: r = 32'h3070DD17;
        3'd3: r = 32'hF70E5939;
        3'd4: r = 32'hFFC00B31;
        3'd5: r = 32'h68581511;
        3'd6: r = 32'h64F98FA7;
        3'd7: r = 32'hBEFA4FA4;
        default: r = 32'h0;
      endcase
    end else begin
      unique case (i)
        3'd0: r = 32'h6A09E667;
        3'd1: r = 32'hBB67AE85;
        3'd2: r = 32'h3C6EF372;
        3'd3: r = 32'hA54FF53A;
        3'd4: r = 32'h510E527F;
        3'd5: r = 32'h9B05688C;
        3'd6: r = 32'h1F83D9AB;
        3'd7: r = 32'h5BE0CD19;
        default: r = 32'h0;
      endcase
    end
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

endpackage

>>> design/sha_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte insertion, padding, 64-round compression and digest output.
// -----------------------------------------------------------------------------
module sha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       in_count_i,
  input  logic             in_last_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       out_idx_o,
  output logic             out_last_o,
  output sha_pkg::cmd_t    cmd_o,
  input  sha_pkg::status_t status_i
);

  sha_pkg::state_e state_q, state_d, ret_q, ret_d, nxt;
  logic [1:0] k_q, k_d;
  logic [2:0] n_q, n_d;
  logic       last_q, last_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic [2:0] last_idx;
  logic [2:0] sat_count;

  assign last_idx  = status_i.variant ? sha_pkg::LastIdx224 : sha_pkg::LastIdx256;
  assign sat_count = (in_count_i > sha_pkg::MaxBytes) ? sha_pkg::MaxBytes : in_count_i;

  // Hold state and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::StIdle;
      ret_q   <= sha_pkg::StIdle;
      k_q     <= '0;
      n_q     <= '0;
      last_q  <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      k_q     <= k_d;
      n_q     <= n_d;
      last_q  <= last_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    k_d         = k_q;
    n_d         = n_q;
    last_d      = last_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    nxt         = sha_pkg::StIdle;
    cmd_o       = '0;
    cmd_o.byte_src = sha_pkg::SrcZero;
    cmd_o.rnd      = rnd_q;
    cmd_o.out_idx  = idx_q;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      sha_pkg::StIdle: begin
        cfg_ready_o = 1'b1;
        in_ready_o  = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
        end else if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          n_d    = sat_count;
          last_d = in_last_i;
          k_d    = '0;
          if (sat_count != 3'd0) begin
            state_d = sha_pkg::StByte;
          end else if (in_last_i) begin
            state_d = sha_pkg::StPad80;
          end
        end
      end
      sha_pkg::StByte: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_src = sha_pkg::SrcData;
        cmd_o.byte_idx = k_q;
        k_d = k_q + 2'd1;
        if (({1'b0, k_q} + 3'd1) == n_q) begin
          nxt = last_q ? sha_pkg::StPad80 : sha_pkg::StIdle;
        end else begin
          nxt = sha_pkg::StByte;
        end
        if (status_i.pos_end) begin
          cmd_o.start_cmp = 1'b1;
          ret_d   = nxt;
          rnd_d   = '0;
          state_d = sha_pkg::StRound;
        end else begin
          state_d = nxt;
        end
      end
      sha_pkg::StPad80: begin
        cmd_o.cap_len  = 1'b1;
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_src = sha_pkg::SrcPad;
        if (status_i.pos_end) begin
          cmd_o.start_cmp = 1'b1;
          ret_d   = sha_pkg::StPadZero;
          rnd_d   = '0;
          state_d = sha_pkg::StRound;
        end else begin
          state_d = sha_pkg::StPadZero;
        end
      end
      sha_pkg::StPadZero: begin
        if (status_i.pos_len) begin
          state_d = sha_pkg::StLen;
        end else begin
          cmd_o.wr_byte  = 1'b1;
          cmd_o.byte_src = sha_pkg::SrcZero;
          if (status_i.pos_end) begin
            cmd_o.start_cmp = 1'b1;
            ret_d   = sha_pkg::StPadZero;
            rnd_d   = '0;
            state_d = sha_pkg::StRound;
          end
        end
      end
      sha_pkg::StLen: begin
        cmd_o.wr_len    = 1'b1;
        cmd_o.start_cmp = 1'b1;
        ret_d   = sha_pkg::StEmit;
        rnd_d   = '0;
        state_d = sha_pkg::StRound;
      end
      sha_pkg::StRound: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == sha_pkg::PosLast) begin
          state_d = sha_pkg::StAdd;
        end
      end
      sha_pkg::StAdd: begin
        cmd_o.add_chain = 1'b1;
        idx_d   = '0;
        state_d = ret_q;
      end
      sha_pkg::StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == last_idx) begin
            cmd_o.reload_iv = 1'b1;
            state_d = sha_pkg::StIdle;
          end
        end
      end
      default: state_d = sha_pkg::StIdle;
    endcase
  end

  assign out_idx_o  = idx_q;
  assign out_last_o = (idx_q == last_idx);

endmodule

>>> design/sha_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha_dp
// Datapath: block buffer and schedule window, round unit, chaining value,
// byte counter and variant register.
// -----------------------------------------------------------------------------
module sha_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      in_word_i,
  input  logic             cfg_data_i,
  input  sha_pkg::cmd_t    cmd_i,
  output sha_pkg::status_t status_o,
  output logic [31:0]      digest_o
);

  logic [31:0] win_q [16];
  logic [31:0] v_q   [8];
  logic [31:0] cv_q  [8];
  logic [31:0] word_q;
  logic [60:0] cnt_q;
  logic [60:0] len_q;
  logic        var_q;

  logic [5:0]  pos;
  logic [7:0]  byte_val;
  logic [31:0] t1, t2, sched_new;

  assign pos = cnt_q[5:0];

  // Select the byte to insert
  always_comb begin
    unique case (cmd_i.byte_src)
      sha_pkg::SrcData: byte_val = word_q[(5'd31 - {cmd_i.byte_idx, 3'b000}) -: 8];
      sha_pkg::SrcPad:  byte_val = sha_pkg::PadByte;
      default:          byte_val = 8'h00;
    endcase
  end

  // Round and schedule arithmetic
  assign t1 = v_q[7] + sha_pkg::big_s1(v_q[4])
            + (v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6])))
            + sha_pkg::RoundK[cmd_i.rnd] + win_q[0];
  assign t2 = sha_pkg::big_s0(v_q[0])
            + ((v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1])));
  assign sched_new = sha_pkg::small_s1(win_q[14]) + win_q[9]
                   + sha_pkg::small_s0(win_q[1]) + win_q[0];

  // Block buffer and schedule window
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      word_q <= in_word_i;
    end
    if (cmd_i.cap_len) begin
      len_q <= cnt_q;
    end
    if (cmd_i.wr_byte) begin
      win_q[pos[5:2]][(5'd31 - {pos[1:0], 3'b000}) -: 8] <= byte_val;
    end
    if (cmd_i.wr_len) begin
      win_q[14] <= len_q[60:29];
      win_q[15] <= {len_q[28:0], 3'b000};
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= sched_new;
    end
    // Working variables
    if (cmd_i.start_cmp) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= cv_q[i];
      end
    end else if (cmd_i.round) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  // Chaining value, byte counter and variant
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_q <= 1'b0;
      cnt_q <= '0;
      for (int i = 0; i < 8; i++) begin
        cv_q[i] <= sha_pkg::init_value(1'b0, 3'(i));
      end
    end else begin
      if (cmd_i.cfg_we) begin
        var_q <= cfg_data_i;
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) begin
          cv_q[i] <= sha_pkg::init_value(cfg_data_i, 3'(i));
        end
      end else if (cmd_i.reload_iv) begin
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) begin
          cv_q[i] <= sha_pkg::init_value(var_q, 3'(i));
        end
      end else begin
        if (cmd_i.wr_byte) begin
          cnt_q <= cnt_q + 61'd1;
        end
        if (cmd_i.add_chain) begin
          for (int i = 0; i < 8; i++) begin
            cv_q[i] <= cv_q[i] + v_q[i];
          end
        end
      end
    end
  end

  assign status_o.pos_end = (pos == sha_pkg::PosLast);
  assign status_o.pos_len = (pos == sha_pkg::PosLen);
  assign status_o.variant = var_q;
  assign digest_o = cv_q[cmd_i.out_idx];

endmodule

>>> design/sha256_sha224_hash.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_sha224_hash
// SHA-256 / SHA-224 hasher over a stream of big-endian message words.
// -----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: data_word, tuser: byte_count, tlast: last_item
// m_axis    out        tdata: digest_word, tuser: word_index, tlast: last_word
// cfg       in         cfg_data_i: variant_224
//
// A word is accepted while idle, then its valid bytes are inserted one at a time.
// Each full block runs 64 rounds on the one round unit, then one add.
// A last word pads byte by byte (up to 64 pad bytes, then the length is placed in
// the last two words), runs one or two blocks,
// then presents 8 (or 7) digest words, one per accepted output request.
// After reset the SHA-256 initial values are loaded; no clearing pass.
// Output stalls hold the block; input is taken only while idle.
// -----------------------------------------------------------------------------
module sha256_sha224_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  sha_pkg::cmd_t    cmd;
  sha_pkg::status_t status;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_count_i  (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  sha_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (s_axis_tdata),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .digest_o   (m_axis_tdata)
  );

endmodule

>>> design/sha_chk.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha_chk
// Port-level checks on the digest stream of the hasher.
// -----------------------------------------------------------------------------
module sha_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled digest word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest word changed under stall");

  // Drop input while digest words are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken during digest output");

  // End the digest at index 7 or 6
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 3'd7 || m_axis_tuser == 3'd6)
    else $error("digest ends at wrong index");

  // Advance the index by one between words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tvalid && m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1))
    else $error("digest index skipped");

endmodule

bind sha256_sha224_hash sha_chk u_sha_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/sha256_sha224_hash_chk.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_sha224_hash_chk
// Watches the message, digest and variant channels of the hasher, computes
// the expected digest words on its own and compares every digest request.
// -----------------------------------------------------------------------------
module sha256_sha224_hash_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic [2:0]  s_axis_tuser,   // [2:0] byte_count
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] digest_word
  input  logic [2:0]  m_axis_tuser,   // [2:0] word_index
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          digests_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_t;

  digest_t     digest_q[$];
  logic [31:0] chain[8];
  logic [31:0] blk[16];
  logic [60:0] msg_len;
  logic        sel_224;

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

  // Load the initial chaining value of the current variant
  task automatic restart();
    for (int i = 0; i < 8; i++)
      chain[i] = sha_pkg::init_value(sel_224, i[2:0]);
    msg_len = '0;
  endtask

  task automatic compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int t = 0; t < 8; t++) v[t] = chain[t];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + sha_pkg::RoundK[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain[t] += v[t];
  endtask

  task automatic push_byte(input logic [7:0] b);
    logic [5:0] pos;
    pos = msg_len[5:0];
    blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
    msg_len = msg_len + 61'd1;
    if (pos == 6'h3F) compress();
  endtask

  // Absorb one message word; on the last one pad and queue the digest
  task automatic absorb(input logic [31:0] d, input logic [2:0] n, input logic lst);
    int cnt;
    int nw;
    logic [63:0] bits;
    cnt = (n > 4) ? 4 : n;
    for (int i = 0; i < cnt; i++) push_byte(d[31 - 8*i -: 8]);
    if (lst) begin
      bits = {msg_len, 3'b000};
      push_byte(8'h80);
      while (msg_len[5:0] != 6'd56) push_byte(8'h00);
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      nw = sel_224 ? 7 : 8;
      for (int i = 0; i < nw; i++)
        digest_q.push_back('{chain[i], i[2:0], i == nw - 1});
      restart();
    end
  endtask

  digest_t got, exp_d;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_224 = 1'b0;
      restart();
      digest_q.delete();
      fail_cnt_o <= 0;
      digests_o  <= 0;
    end else begin
      // Compare a digest request against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
        digests_o <= digests_o + 1;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest request %h", $time, got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_d = digest_q.pop_front();
          if (got !== exp_d) begin
            $display("%0t: digest mismatch exp word %h idx %0d last %b, got %h %0d %b",
                     $time, exp_d.word, exp_d.idx, exp_d.last,
                     got.word, got.idx, got.last);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sel_224 = cfg_data_i;
        restart();
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end

  assign pending_o = digest_q.size();

endmodule

>>> bench/sha256_sha224_hash_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_sha224_hash_tb
// Drives messages of varied length and tail size through the hasher in
// both variants under several idle/stall phases; the checker grades digests.
// -----------------------------------------------------------------------------
module sha256_sha224_hash_tb;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  int          fail_cnt, pending, digests;
  int          idle_pct = 0, stall_pct = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sha256_sha224_hash u_dut (.*);

  sha256_sha224_hash_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .s_axis_tlast, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tlast, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending), .digests_o(digests)
  );

  // Stall the digest channel at random
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Watchdog on cycles without any request
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive one word; valid stays high after the accept until the next call
  task automatic send_word(input logic [31:0] d, input logic [2:0] n, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= n;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
  endtask

  // Mostly full words, then a last word holding tail bytes (0..7, above 4 saturates)
  task automatic send_msg(input int full, input logic [2:0] tail);
    for (int i = 0; i < full; i++)
      send_word($urandom, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
    send_word($urandom, tail, 1'b1);
  endtask

  // Drop valid and wait until every expected digest word has come
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_variant(input logic v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, short tails, extremes, block boundaries
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hFFFFFFFF, 3'd7, 1'b1);
    send_word(32'h12345678, 3'd1, 1'b0);
    send_word(32'h9ABCDEF0, 3'd2, 1'b0);
    send_word(32'h0, 3'd4, 1'b1);
    send_msg(13, 3'd3);
    set_variant(1'b1);
    send_word(32'h0, 3'd0, 1'b1);
    send_msg(15, 3'd0);
    // Abandon a message in flight with a variant write
    send_word(32'hA5A5A5A5, 3'd4, 1'b0);
    set_variant(1'b0);
    send_word(32'h5A5A5A5A, 3'd2, 1'b1);
    set_variant(1'b0);

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 29 : 0;
      stall_pct = (ph == 2) ? 70 : (ph == 3) ? 29 : 0;
      set_variant(ph[0]);
      for (int m = 0; m < 6; m++) begin
        if ($urandom_range(3) == 0) send_msg($urandom_range(31), 3'($urandom_range(7)));
        else send_msg($urandom_range(12), 3'($urandom_range(4)));
        if (m == 2) drain();
      end
    end

    drain();
    $display("Sent %0d message words in both variants over four pacing phases,",
             words_sent);
    $display("checked %0d digest words.", digests);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
